/* hdl/u8d_pkg.sv */
// Shared types and codes of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

    // Result status codes
    localparam logic [1:0] ST_CHAR       = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    // Continuation byte form: 10xxxxxx
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam int OUT_COUNT_W = 32;

    // Open sequence state
    typedef struct packed {
        logic [2:0]  len;       // 0 = no sequence open
        logic [2:0]  rcvd;
        logic [30:0] value;
        logic        bad;
        logic        dropping;
    } u8d_seq_t;

    localparam u8d_seq_t SEQ_IDLE = '0;

    // Lead byte decode: sequence length (0 = no form) and payload bits
    typedef struct packed {
        logic [2:0] len;
        logic [6:0] bits;
    } u8d_lead_t;

    // One result request
    typedef struct packed {
        logic [30:0]            code_point;
        logic [1:0]             status;
        logic                   done_res;
        logic [OUT_COUNT_W-1:0] byte_count;
    } u8d_res_t;

endpackage

/* hdl/u8d_if.sv */
// Valid/ready stream interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        done_res;
    logic [31:0] byte_count;

    modport source (output valid, output code_point, output status, output done_res,
                    output byte_count, input ready);
    modport sink   (input valid, input code_point, input status, input done_res,
                    input byte_count, output ready);
endinterface

/* hdl/utf8_stream_decoder.sv */
// UTF-8 (RFC 2279, up to 6-byte forms) stream decoder, top level.
// A result request is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register holds one request and
// the input stalls only while that request waits on the sink.
// Reset: rst_n clears sequence state, byte counter and output valid at once.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    u8d_in_if.sink    bytes,
    u8d_out_if.source chars
);
    import u8d_pkg::*;

    // Decoder state: open sequence and per-stream byte count
    u8d_seq_t               seq_reg;
    u8d_seq_t               seq_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;

    logic     accept;
    logic     can_take;
    logic     res_valid;
    u8d_res_t res;

    // A byte is taken whenever the result stage can take its request.
    // Bytes that make no result (mid-sequence, dropping) pass through too.
    assign bytes.ready = can_take;
    assign accept      = bytes.valid && can_take;

    u8d_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .seq           (seq_reg),
        .count         (count_reg),
        .in_byte       (bytes.in_byte),
        .end_of_stream (bytes.end_of_stream),
        .seq_next      (seq_next),
        .count_next    (count_next),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_IDLE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            seq_reg   <= seq_next;
            count_reg <= count_next;
        end
    end

    // Result register / handshake toward the sink
    u8d_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .chars     (chars)
    );

`ifndef NO_ASSERTIONS
    // Dropping only happens with no sequence open
    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.dropping |-> seq_reg.len == 3'd0)
        else $error("dropping with open sequence");

    // An open sequence never holds its full length
    a_rcvd_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg.len != 3'd0 |-> (seq_reg.rcvd < seq_reg.len && seq_reg.len <= 3'd6))
        else $error("sequence byte count out of range");

    // End of stream returns all state to idle
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.end_of_stream |=> (seq_reg == SEQ_IDLE && count_reg == '0))
        else $error("state not cleared at end of stream");

    // Error results always close the stream
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.status != ST_CHAR |-> chars.done_res)
        else $error("error result without done mark");

    // An error result leaves the decoder dropping unless the stream ended
    a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.status != ST_CHAR && !bytes.end_of_stream
        |=> seq_reg.dropping)
        else $error("error did not start dropping");
`endif

endmodule

/* hdl/u8d_lead_decode.sv */
// Lead byte classifier: sequence length and payload bits of a lead byte.
`timescale 1ns / 1ps

module u8d_lead_decode (
    input  logic [7:0]          lead,
    output u8d_pkg::u8d_lead_t  form
);
    import u8d_pkg::*;

    always_comb
    begin
        form = '0;
        priority if ((lead & 8'h80) == 8'h00)
        begin
            form.len  = 3'd1;
            form.bits = lead[6:0];
        end
        else if ((lead & 8'hE0) == 8'hC0)
        begin
            form.len  = 3'd2;
            form.bits = {2'b00, lead[4:0]};
        end
        else if ((lead & 8'hF0) == 8'hE0)
        begin
            form.len  = 3'd3;
            form.bits = {3'b000, lead[3:0]};
        end
        else if ((lead & 8'hF8) == 8'hF0)
        begin
            form.len  = 3'd4;
            form.bits = {4'b0000, lead[2:0]};
        end
        else if ((lead & 8'hFC) == 8'hF8)
        begin
            form.len  = 3'd5;
            form.bits = {5'b00000, lead[1:0]};
        end
        else if ((lead & 8'hFE) == 8'hFC)
        begin
            form.len  = 3'd6;
            form.bits = {6'b000000, lead[0]};
        end
        else
        begin
            form = '0;  // bare continuation, 0xFE, 0xFF
        end
    end

endmodule

/* hdl/u8d_step.sv */
// Next-state and result logic for one input byte.
`timescale 1ns / 1ps

module u8d_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  u8d_pkg::u8d_seq_t       seq,
    input  logic [COUNT_WIDTH-1:0]  count,
    input  logic [7:0]              in_byte,
    input  logic                    end_of_stream,
    output u8d_pkg::u8d_seq_t       seq_next,
    output logic [COUNT_WIDTH-1:0]  count_next,
    output logic                    res_valid,
    output u8d_pkg::u8d_res_t       res
);
    import u8d_pkg::*;

    u8d_lead_t              form;
    u8d_seq_t               work;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] count_sat;
    logic [63:0]            count_wide;
    logic [63:0]            sat_wide;

    u8d_lead_decode u_lead (
        .lead (in_byte),
        .form (form)
    );

    // Sequence after this byte is folded in (lead or continuation)
    always_comb
    begin
        work = seq;
        if (seq.len == 3'd0)
        begin
            work.len   = form.len;
            work.rcvd  = 3'd1;
            work.value = {24'd0, form.bits};
            work.bad   = 1'b0;
        end
        else
        begin
            work.bad   = seq.bad | ((in_byte & CONT_MASK) != CONT_TAG);
            work.value = {seq.value[24:0], in_byte[5:0]};
            work.rcvd  = seq.rcvd + 3'd1;
        end
    end

    // Saturating byte counter
    assign sum        = {1'b0, count} + (COUNT_WIDTH + 1)'(work.len);
    assign count_sat  = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
    assign count_wide = 64'(count);
    assign sat_wide   = 64'(count_sat);

    always_comb
    begin
        seq_next       = seq;
        count_next     = count;
        res_valid      = 1'b0;
        res            = '0;
        res.byte_count = count_wide[OUT_COUNT_W-1:0];

        if (seq.dropping)
        begin
            if (end_of_stream)
            begin
                seq_next   = SEQ_IDLE;
                count_next = '0;
            end
        end
        else if (seq.len == 3'd0 && form.len == 3'd0)
        begin
            // bad lead byte
            res_valid         = 1'b1;
            res.status        = ST_INVALID;
            res.done_res      = 1'b1;
            seq_next          = SEQ_IDLE;
            seq_next.dropping = !end_of_stream;
            if (end_of_stream)
                count_next = '0;
        end
        else
        begin
            seq_next = work;
            if (work.rcvd >= work.len)
            begin
                seq_next  = SEQ_IDLE;
                res_valid = 1'b1;
                if (work.bad)
                begin
                    res.status        = ST_INVALID;
                    res.done_res      = 1'b1;
                    seq_next.dropping = !end_of_stream;
                end
                else
                begin
                    res.code_point = work.value;
                    res.status     = ST_CHAR;
                    res.done_res   = end_of_stream;
                    res.byte_count = sat_wide[OUT_COUNT_W-1:0];
                    count_next     = count_sat;
                end
            end
            else if (end_of_stream)
            begin
                res_valid    = 1'b1;
                res.status   = ST_INCOMPLETE;
                res.done_res = 1'b1;
            end

            if (end_of_stream)
            begin
                seq_next   = SEQ_IDLE;
                count_next = '0;
            end
        end
    end

endmodule

/* hdl/u8d_out_reg.sv */
// Result register stage with valid/ready handshake toward the sink.
`timescale 1ns / 1ps

module u8d_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              res_valid,
    input  u8d_pkg::u8d_res_t res,
    output logic              can_take,
    u8d_out_if.source         chars
);
    import u8d_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    u8d_res_t res_reg;

    // Stage frees up when empty or when its request is taken this cycle
    assign can_take   = !valid_reg || chars.ready;
    assign valid_next = can_take ? (load && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
            res_reg <= res;
    end

    assign chars.valid      = valid_reg;
    assign chars.code_point = res_reg.code_point;
    assign chars.status     = res_reg.status;
    assign chars.done_res   = res_reg.done_res;
    assign chars.byte_count = res_reg.byte_count;

endmodule
